// ----- sv/hpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hpa_pkg;

    localparam int SLOTS    = 64;
    localparam int ID_WIDTH = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int TYPE_W   = 3;

    typedef enum logic [TYPE_W-1:0] {
        OP_CREATE   = 3'd0,
        OP_FREE     = 3'd1,
        OP_EXISTS   = 3'd2,
        OP_LOOKUP   = 3'd3,
        OP_FIRST    = 3'd4,
        OP_NEXT     = 3'd5,
        OP_HAS_NEXT = 3'd6,
        OP_FREE_ALL = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_QRES,
        ST_FREE,
        ST_CLR
    } state_t;

    typedef struct packed {
        logic load;
        logic pop;
        logic scan;
        logic qres;
        logic free_step;
        logic free_done;
        logic clr_step;
        logic clr_done;
    } cmd_t;

    typedef struct packed {
        logic match_any;
        logic live_any;
    } stat_t;

endpackage

`default_nettype wire

// ----- sv/hpa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/hpa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpa_ctrl
    import hpa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [TYPE_W-1:0] req_type,
    input  wire stat_t             stat,
    output logic                   busy,
    output cmd_t                   cmd
);

    state_t state_reg;
    state_t state_next;
    op_t    op_in;

    assign op_in = op_t'(req_type);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (op_in)
                        OP_CREATE:   state_next = ST_POP;
                        OP_FREE:     state_next = ST_FREE;
                        OP_FREE_ALL: state_next = ST_CLR;
                        default:     state_next = ST_SCAN;
                    endcase
                end
            end
            ST_POP:  state_next = ST_IDLE;
            ST_SCAN: state_next = ST_QRES;
            ST_QRES: state_next = ST_IDLE;
            ST_FREE:
            begin
                if (!stat.match_any)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                if (!stat.live_any)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_POP:  cmd.pop  = 1'b1;
            ST_SCAN: cmd.scan = 1'b1;
            ST_QRES: cmd.qres = 1'b1;
            ST_FREE:
            begin
                cmd.free_step = stat.match_any;
                cmd.free_done = !stat.match_any;
            end
            ST_CLR:
            begin
                cmd.clr_step = stat.live_any;
                cmd.clr_done = !stat.live_any;
            end
            default: busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/hpa_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpa_dp
    import hpa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    input  wire logic [TYPE_W-1:0]   req_type,
    input  wire logic [ID_WIDTH-1:0] req_id,
    output stat_t                    stat,
    output logic                     done,
    output logic                     found,
    output logic [SLOT_W-1:0]        slot,
    output logic [ID_WIDTH-1:0]      slot_handle,
    output logic [CNT_W-1:0]         live_count
);

    op_t                 op_reg, op_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [SLOTS-1:0]    stk_vld_reg, stk_vld_next;
    logic [ID_WIDTH-1:0] ident_reg [SLOTS];
    logic [CNT_W-1:0]    depth_reg, depth_next;
    logic [ID_WIDTH-1:0] counter_reg, counter_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic [CNT_W-1:0]    cursor_reg, cursor_next;
    logic [SLOT_W-1:0]   hit_reg, hit_next;
    logic                hit_any_reg, hit_any_next;
    logic                freed_any_reg, freed_any_next;
    logic [SLOT_W-1:0]   first_reg, first_next;
    logic                done_reg, done_next;
    logic                found_reg, found_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [ID_WIDTH-1:0] handle_reg, handle_next;

    logic [SLOTS-1:0]    match_vec;
    logic [SLOTS-1:0]    scan_vec;
    logic [SLOT_W-1:0]   scan_hit;
    logic [SLOT_W-1:0]   free_hit;
    logic [SLOT_W-1:0]   clr_hit;
    logic [SLOT_W-1:0]   pop_idx;
    logic [SLOT_W-1:0]   pop_slot;
    logic [SLOT_W-1:0]   stk_rdata;
    logic                stk_we;
    logic [SLOT_W-1:0]   stk_wdata;
    logic                ident_we;
    logic [ID_WIDTH-1:0] ident_rdata;

    function automatic logic [SLOT_W-1:0] lowest(input logic [SLOTS-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] highest(input logic [SLOTS-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (v[i])
            begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match_vec[i] = valid_reg[i] && (ident_reg[i] == id_reg);
            unique case (op_reg)
                OP_EXISTS, OP_LOOKUP: scan_vec[i] = match_vec[i];
                OP_FIRST:             scan_vec[i] = valid_reg[i];
                default:              scan_vec[i] = valid_reg[i] && (CNT_W'(i) >= cursor_reg);
            endcase
        end
    end

    assign scan_hit = lowest(scan_vec);
    assign free_hit = lowest(match_vec);
    assign clr_hit  = highest(valid_reg);

    assign stat.match_any = |match_vec;
    assign stat.live_any  = |valid_reg;

    // The top of the free list sits at one below the depth; entries never
    // written since reset hold their initial slot number.
    assign pop_idx  = SLOT_W'(depth_reg - CNT_W'(1));
    assign pop_slot = stk_vld_reg[pop_idx] ? stk_rdata : (SLOT_W'(SLOTS - 1) - pop_idx);

    assign stk_we    = cmd.free_step || cmd.clr_step;
    assign stk_wdata = cmd.free_step ? free_hit : clr_hit;
    assign ident_we  = cmd.pop && (depth_reg != '0);

    hpa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (depth_reg[SLOT_W-1:0]),
        .wdata (stk_wdata),
        .raddr (pop_idx),
        .rdata (stk_rdata)
    );

    hpa_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (SLOTS)
    ) u_ident_ram (
        .clk   (clk),
        .we    (ident_we),
        .waddr (pop_slot),
        .wdata (counter_reg),
        .raddr (scan_hit),
        .rdata (ident_rdata)
    );

    always_comb
    begin
        op_next        = op_reg;
        id_next        = id_reg;
        valid_next     = valid_reg;
        stk_vld_next   = stk_vld_reg;
        depth_next     = depth_reg;
        counter_next   = counter_reg;
        live_next      = live_reg;
        cursor_next    = cursor_reg;
        hit_next       = hit_reg;
        hit_any_next   = hit_any_reg;
        freed_any_next = freed_any_reg;
        first_next     = first_reg;
        done_next      = 1'b0;
        found_next     = found_reg;
        slot_next      = slot_reg;
        handle_next    = handle_reg;

        if (cmd.load)
        begin
            op_next        = op_t'(req_type);
            id_next        = req_id;
            freed_any_next = 1'b0;
        end

        if (cmd.pop)
        begin
            done_next   = 1'b1;
            found_next  = 1'b0;
            slot_next   = '0;
            handle_next = '0;
            if (depth_reg != '0)
            begin
                valid_next[pop_slot] = 1'b1;
                depth_next           = depth_reg - CNT_W'(1);
                counter_next         = counter_reg + ID_WIDTH'(1);
                live_next            = live_reg + CNT_W'(1);
                found_next           = 1'b1;
                slot_next            = pop_slot;
                handle_next          = counter_reg;
            end
        end

        if (cmd.scan)
        begin
            hit_next     = scan_hit;
            hit_any_next = |scan_vec;
        end

        if (cmd.qres)
        begin
            done_next   = 1'b1;
            found_next  = hit_any_reg;
            slot_next   = hit_any_reg ? hit_reg : '0;
            handle_next = hit_any_reg ? ident_rdata : '0;
            if (hit_any_reg && (op_reg == OP_LOOKUP || op_reg == OP_FIRST ||
                                op_reg == OP_NEXT))
            begin
                cursor_next = CNT_W'(hit_reg) + CNT_W'(1);
            end
        end

        if (cmd.free_step)
        begin
            valid_next[free_hit]                  = 1'b0;
            stk_vld_next[depth_reg[SLOT_W-1:0]]   = 1'b1;
            depth_next                            = depth_reg + CNT_W'(1);
            live_next                             = live_reg - CNT_W'(1);
            freed_any_next                        = 1'b1;
            if (!freed_any_reg)
            begin
                first_next = free_hit;
            end
        end

        if (cmd.free_done)
        begin
            done_next   = 1'b1;
            found_next  = freed_any_reg;
            slot_next   = freed_any_reg ? first_reg : '0;
            handle_next = freed_any_reg ? id_reg : '0;
        end

        if (cmd.clr_step)
        begin
            valid_next[clr_hit]                 = 1'b0;
            stk_vld_next[depth_reg[SLOT_W-1:0]] = 1'b1;
            depth_next                          = depth_reg + CNT_W'(1);
            live_next                           = live_reg - CNT_W'(1);
        end

        if (cmd.clr_done)
        begin
            done_next    = 1'b1;
            found_next   = 1'b1;
            slot_next    = '0;
            handle_next  = '0;
            counter_next = '0;
            cursor_next  = '0;
            live_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            stk_vld_reg   <= '0;
            depth_reg     <= CNT_W'(SLOTS);
            counter_reg   <= '0;
            live_reg      <= '0;
            cursor_reg    <= '0;
            hit_any_reg   <= 1'b0;
            freed_any_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            stk_vld_reg   <= stk_vld_next;
            depth_reg     <= depth_next;
            counter_reg   <= counter_next;
            live_reg      <= live_next;
            cursor_reg    <= cursor_next;
            hit_any_reg   <= hit_any_next;
            freed_any_reg <= freed_any_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        hit_reg    <= hit_next;
        first_reg  <= first_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        handle_reg <= handle_next;
        if (ident_we)
        begin
            ident_reg[pop_slot] <= counter_reg;
        end
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign slot        = slot_reg;
    assign slot_handle = handle_reg;
    assign live_count  = live_reg;

endmodule

`default_nettype wire

// ----- sv/handle_pool_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Handle pool allocator: a pool of 64 slots with a last-in first-out free list
// and a wrapping 16-bit id counter. A request word is taken when start is high
// and busy is low, and exactly one result word follows, shown for a single
// cycle with done high in the same cycle that busy drops; the receiver cannot
// hold it off, so it must capture the word in that cycle. A create passes
// through the pop state before the next accept, while exists, lookup, first,
// next and has_next pass through the scan and result states, since the
// live-slot scan is registered before the id memory is read. A free and a
// free-all stay busy until every matching slot, or every live slot, has been
// released, because the free list memory has one write port and takes one
// released slot per cycle. No clearing pass is needed after reset.
module handle_pool_allocator
    import hpa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [TYPE_W-1:0]   req_type,
    input  wire logic [ID_WIDTH-1:0] req_id,
    output logic                     done,
    output logic                     found,
    output logic [SLOT_W-1:0]        slot,
    output logic [ID_WIDTH-1:0]      slot_handle,
    output logic [CNT_W-1:0]         live_count
);

    cmd_t  cmd;
    stat_t stat;

    hpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    hpa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .req_id      (req_id),
        .stat        (stat),
        .done        (done),
        .found       (found),
        .slot        (slot),
        .slot_handle (slot_handle),
        .live_count  (live_count)
    );

endmodule

`default_nettype wire

// ----- sv/hpa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hpa_checker
    import hpa_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire logic                found,
    input wire logic [SLOT_W-1:0]   slot,
    input wire logic [ID_WIDTH-1:0] slot_handle,
    input wire logic [CNT_W-1:0]    live_count
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (slot == '0 && slot_handle == '0))
        else $error("miss result carries a nonzero slot or handle");

    a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (live_count <= CNT_W'(SLOTS)))
        else $error("live count exceeds pool size");

endmodule

bind handle_pool_allocator hpa_checker u_hpa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .found       (found),
    .slot        (slot),
    .slot_handle (slot_handle),
    .live_count  (live_count)
);

`default_nettype wire
